// ----- hdl/float_exp_poly_unit_top_defines.svh -----
// Assertion helpers for the top module of the exponential unit.
`ifndef FLOAT_EXP_POLY_UNIT_TOP_DEFINES_SVH
`define FLOAT_EXP_POLY_UNIT_TOP_DEFINES_SVH

// Checks the consequent in the same cycle as the antecedent.
`define FEP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks the consequent in the cycle after the antecedent.
`define FEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/fep_pkg.sv -----
`timescale 1ns / 1ps

package fep_pkg;

  localparam logic [31:0] SignBit  = 32'h8000_0000;
  localparam logic [31:0] QnanBits = 32'h7FC0_0000;
  localparam logic [31:0] OneBits  = 32'h3F80_0000;
  localparam logic [31:0] Shifter  = 32'h4B40_0000;
  localparam logic [31:0] Log2e    = 32'h3FB8_AA3B;
  localparam logic [31:0] Ln2Hi    = 32'h3F31_7200;
  localparam logic [31:0] Ln2Lo    = 32'h35BF_BE8E;
  localparam logic [31:0] Pc0      = 32'h3F7F_FFF6;
  localparam logic [31:0] Pc1      = 32'h3EFF_FEDB;
  localparam logic [31:0] Pc2      = 32'h3E2A_AF33;
  localparam logic [31:0] Pc3      = 32'h3D2B_9F17;
  localparam logic [31:0] Pc4      = 32'h3C07_2010;
  localparam logic [31:0] Limit80  = 32'h42A0_0000;

  localparam int ExpShift  = 23;
  // Register stages inside one fused multiply-add.
  localparam int FmaLat    = 5;
  // Dependent multiply-adds from argument to result.
  localparam int FmaLevels = 8;
  localparam int PipeLat   = FmaLat * FmaLevels;

  typedef logic signed [11:0] exp_t;

endpackage

// ----- hdl/fep_fma.sv -----
`timescale 1ns / 1ps

module fep_fma (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  output logic [31:0] y_o
);
  import fep_pkg::*;

  function automatic logic [5:0] lead_zeros(input logic [63:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd0;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(63 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Right shift that folds every lost bit into bit zero.
  function automatic logic [63:0] shr_sticky(input logic [63:0] v, input logic [11:0] d);
    logic [63:0] lost;
    logic [63:0] res;
    if (d >= 12'd63) begin
      res = {63'd0, (v != 64'd0)};
    end else begin
      lost = v & ((64'd1 << d[5:0]) - 64'd1);
      res = (v >> d[5:0]) | {63'd0, (lost != 64'd0)};
    end
    return res;
  endfunction

  // Stage 1: unpack, special operands, significand product.
  logic        a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero;
  logic        sp, sc;
  logic [23:0] ma, mb, mc;
  logic [7:0]  ea, eb, ec;
  logic        spec1_d;
  logic [31:0] sval1_d;

  assign a_nan  = a_i[30:0] > 31'h7F80_0000;
  assign b_nan  = b_i[30:0] > 31'h7F80_0000;
  assign c_nan  = c_i[30:0] > 31'h7F80_0000;
  assign a_inf  = a_i[30:0] == 31'h7F80_0000;
  assign b_inf  = b_i[30:0] == 31'h7F80_0000;
  assign c_inf  = c_i[30:0] == 31'h7F80_0000;
  assign a_zero = a_i[30:0] == 31'd0;
  assign b_zero = b_i[30:0] == 31'd0;
  assign c_zero = c_i[30:0] == 31'd0;
  assign sp     = a_i[31] ^ b_i[31];
  assign sc     = c_i[31];
  assign ma     = {(a_i[30:23] != 8'd0), a_i[22:0]};
  assign mb     = {(b_i[30:23] != 8'd0), b_i[22:0]};
  assign mc     = {(c_i[30:23] != 8'd0), c_i[22:0]};
  assign ea     = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
  assign eb     = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
  assign ec     = (c_i[30:23] == 8'd0) ? 8'd1 : c_i[30:23];

  always_comb begin
    spec1_d = 1'b1;
    sval1_d = QnanBits;
    if (a_nan || b_nan || c_nan) begin
      sval1_d = QnanBits;
    end else if (a_inf || b_inf) begin
      if (a_zero || b_zero) begin
        sval1_d = QnanBits;
      end else if (c_inf && (sc != sp)) begin
        sval1_d = QnanBits;
      end else begin
        sval1_d = {sp, 31'h7F80_0000};
      end
    end else if (c_inf) begin
      sval1_d = c_i;
    end else if (a_zero || b_zero) begin
      sval1_d = c_zero ? {sp & sc, 31'd0} : c_i;
    end else begin
      spec1_d = 1'b0;
    end
  end

  logic [47:0] mp1_q;
  logic [8:0]  eab1_q;
  logic [23:0] mc1_q;
  logic [7:0]  ec1_q;
  logic        sp1_q, sc1_q, cz1_q, spec1_q;
  logic [31:0] sval1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mp1_q   <= ma * mb;
      eab1_q  <= {1'b0, ea} + {1'b0, eb};
      mc1_q   <= mc;
      ec1_q   <= ec;
      sp1_q   <= sp;
      sc1_q   <= sc;
      cz1_q   <= c_zero;
      spec1_q <= spec1_d;
      sval1_q <= sval1_d;
    end
  end

  // Stage 2: normalize both addends so that the leading one sits at bit 61.
  logic [5:0]  lzp, lzc;
  logic [63:0] mpn2_d, mcn2_d;
  exp_t        ep2_d, ec2_d;

  assign lzp    = lead_zeros({mp1_q, 16'd0});
  assign lzc    = lead_zeros({mc1_q, 40'd0});
  assign mpn2_d = ({mp1_q, 16'd0} << lzp) >> 2;
  assign mcn2_d = ({mc1_q, 40'd0} << lzc) >> 2;
  assign ep2_d  = exp_t'({3'd0, eab1_q}) - exp_t'(314) - exp_t'({6'd0, lzp});
  assign ec2_d  = exp_t'({4'd0, ec1_q}) - exp_t'(188) - exp_t'({6'd0, lzc});

  logic [63:0] mpn2_q, mcn2_q;
  exp_t        ep2_q, ec2_q;
  logic        sp2_q, sc2_q, cz2_q, spec2_q;
  logic [31:0] sval2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mpn2_q  <= mpn2_d;
      mcn2_q  <= mcn2_d;
      ep2_q   <= ep2_d;
      ec2_q   <= ec2_d;
      sp2_q   <= sp1_q;
      sc2_q   <= sc1_q;
      cz2_q   <= cz1_q;
      spec2_q <= spec1_q;
      sval2_q <= sval1_q;
    end
  end

  // Stage 3: align the smaller addend and add or subtract.
  exp_t        diff;
  logic [63:0] mps, mcs, r3_d;
  exp_t        e3_d;
  logic        sr3_d;

  assign diff = ep2_q - ec2_q;

  always_comb begin
    if (cz2_q) begin
      mps  = mpn2_q;
      mcs  = 64'd0;
      e3_d = ep2_q;
    end else if (!diff[11]) begin
      mps  = mpn2_q;
      mcs  = shr_sticky(mcn2_q, diff);
      e3_d = ep2_q;
    end else begin
      mps  = shr_sticky(mpn2_q, -diff);
      mcs  = mcn2_q;
      e3_d = ec2_q;
    end
    if (sp2_q == sc2_q) begin
      r3_d  = mps + mcs;
      sr3_d = sp2_q;
    end else if (mps >= mcs) begin
      r3_d  = mps - mcs;
      sr3_d = sp2_q;
    end else begin
      r3_d  = mcs - mps;
      sr3_d = sc2_q;
    end
  end

  logic [62:0] r3_q;
  exp_t        e3_q;
  logic        sr3_q, rz3_q, spec3_q;
  logic [31:0] sval3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r3_q    <= r3_d[62:0];
      e3_q    <= e3_d;
      sr3_q   <= sr3_d;
      rz3_q   <= (r3_d == 64'd0);
      spec3_q <= spec2_q;
      sval3_q <= sval2_q;
    end
  end

  // Stage 4: bring the leading one of the sum to bit 62.
  logic [5:0] lzr;

  assign lzr = lead_zeros({r3_q, 1'b0});

  logic [62:0] rn4_q;
  exp_t        be4_q;
  logic        sr4_q, rz4_q, spec4_q;
  logic [31:0] sval4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rn4_q   <= r3_q << lzr;
      be4_q   <= e3_q - exp_t'({6'd0, lzr}) + exp_t'(189);
      sr4_q   <= sr3_q;
      rz4_q   <= rz3_q;
      spec4_q <= spec3_q;
      sval4_q <= sval3_q;
    end
  end

  // Stage 5: round to nearest even, with gradual underflow.
  logic        sub;
  exp_t        sh;
  logic [5:0]  shm1;
  logic [63:0] tmp, mask;
  logic        sticky, up;
  logic [23:0] mant;
  logic [7:0]  be_m1;
  logic [30:0] mag;
  logic [31:0] res5_d;

  assign sub    = be4_q < exp_t'(1);
  assign sh     = exp_t'(39) + (sub ? (exp_t'(1) - be4_q) : exp_t'(0));
  assign shm1   = sh[5:0] - 6'd1;
  assign tmp    = {1'b0, rn4_q} >> shm1;
  assign mask   = (64'd1 << shm1) - 64'd1;
  assign sticky = ({1'b0, rn4_q} & mask) != 64'd0;
  assign mant   = tmp[24:1];
  assign up     = tmp[0] && (sticky || mant[0]);
  assign be_m1  = sub ? 8'd0 : 8'(be4_q - exp_t'(1));
  assign mag    = {be_m1, 23'd0} + {7'd0, mant} + {30'd0, up};

  always_comb begin
    if (spec4_q) begin
      res5_d = sval4_q;
    end else if (rz4_q) begin
      res5_d = 32'd0;
    end else if (be4_q > exp_t'(254)) begin
      res5_d = {sr4_q, 31'h7F80_0000};
    end else if (sh >= exp_t'(64)) begin
      res5_d = {sr4_q, 31'd0};
    end else begin
      res5_d = {sr4_q, mag};
    end
  end

  logic [31:0] y5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y5_q <= res5_d;
    end
  end

  assign y_o = y5_q;

endmodule

// ----- hdl/float_exp_poly_unit_top.sv -----
// Natural exponential of one binary32 argument, built from eight dependent levels of
// fused multiply-adds (five register stages each) between an accepted beat and its
// result. A new argument is taken every cycle; the whole pipeline holds while a
// finished result waits at the output, so throughput is one beat per cycle
// whenever the output side takes results. The result always carries the formula's
// value; domain_error_o marks arguments that are NaN, infinite or beyond +-80.
`timescale 1ns / 1ps
`include "float_exp_poly_unit_top_defines.svh"

module float_exp_poly_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] x_bits_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] y_bits_o,
  output logic        last_res_o,
  output logic        domain_error_o
);
  import fep_pkg::*;

  localparam int XDly = 2 * FmaLat;
  localparam int KDly = 6 * FmaLat;

  logic en;
  logic [PipeLat-1:0] vld_q, last_q, dom_q;

  // The pipeline moves only when the output register is free or being emptied.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeLat-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q <= {last_q[PipeLat-2:0], last_i};
      dom_q  <= {dom_q[PipeLat-2:0], (x_bits_i[30:0] > Limit80[30:0])};
    end
  end

  logic [31:0] z_w, n_w, b1_w, b_w, u_w, p_w, q_w, m0_w, p2_w, j_w, y_w, k_w;
  logic [31:0] x_dly_q  [XDly];
  logic [31:0] n_dly_q  [FmaLat];
  logic [31:0] u_dly_q  [FmaLat];
  logic [31:0] m0_dly_q [FmaLat];
  logic [31:0] k_dly_q  [KDly];

  assign k_w = (z_w << ExpShift) + OneBits;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_dly_q[0]  <= x_bits_i;
      k_dly_q[0]  <= k_w;
      n_dly_q[0]  <= n_w;
      u_dly_q[0]  <= u_w;
      m0_dly_q[0] <= m0_w;
      for (int i = 1; i < XDly; i++) begin
        x_dly_q[i] <= x_dly_q[i-1];
      end
      for (int i = 1; i < KDly; i++) begin
        k_dly_q[i] <= k_dly_q[i-1];
      end
      for (int i = 1; i < FmaLat; i++) begin
        n_dly_q[i]  <= n_dly_q[i-1];
        u_dly_q[i]  <= u_dly_q[i-1];
        m0_dly_q[i] <= m0_dly_q[i-1];
      end
    end
  end

  // Range reduction.
  fep_fma u_z (.clk_i, .en_i(en), .a_i(x_bits_i), .b_i(Log2e), .c_i(Shifter), .y_o(z_w));
  fep_fma u_n (.clk_i, .en_i(en), .a_i(z_w), .b_i(OneBits), .c_i(Shifter ^ SignBit),
               .y_o(n_w));
  fep_fma u_b1 (.clk_i, .en_i(en), .a_i(n_w), .b_i(Ln2Hi ^ SignBit),
                .c_i(x_dly_q[XDly-1]), .y_o(b1_w));
  fep_fma u_b (.clk_i, .en_i(en), .a_i(n_dly_q[FmaLat-1]), .b_i(Ln2Lo ^ SignBit),
               .c_i(b1_w), .y_o(b_w));

  // Polynomial terms that only need b.
  fep_fma u_u (.clk_i, .en_i(en), .a_i(b_w), .b_i(b_w), .c_i(SignBit), .y_o(u_w));
  fep_fma u_p (.clk_i, .en_i(en), .a_i(Pc2), .b_i(b_w), .c_i(Pc1), .y_o(p_w));
  fep_fma u_q (.clk_i, .en_i(en), .a_i(Pc4), .b_i(b_w), .c_i(Pc3), .y_o(q_w));
  fep_fma u_m0 (.clk_i, .en_i(en), .a_i(Pc0), .b_i(b_w), .c_i(SignBit), .y_o(m0_w));

  fep_fma u_p2 (.clk_i, .en_i(en), .a_i(q_w), .b_i(u_w), .c_i(p_w), .y_o(p2_w));
  fep_fma u_j (.clk_i, .en_i(en), .a_i(p2_w), .b_i(u_dly_q[FmaLat-1]),
               .c_i(m0_dly_q[FmaLat-1]), .y_o(j_w));

  // Scale: k + j*k.
  fep_fma u_y (.clk_i, .en_i(en), .a_i(j_w), .b_i(k_dly_q[KDly-1]),
               .c_i(k_dly_q[KDly-1]), .y_o(y_w));

  assign out_valid_o    = vld_q[PipeLat-1];
  assign y_bits_o       = y_w;
  assign last_res_o     = last_q[PipeLat-1];
  assign domain_error_o = dom_q[PipeLat-1];

  `FEP_ASSERT_NEXT(a_stall_holds, !in_ready_o, $stable(vld_q),
                   "pipeline valid bits moved during a stall")
  `FEP_ASSERT_NEXT(a_beat_enters, in_valid_i && in_ready_o, vld_q[0],
                   "accepted beat did not enter the pipeline")
  `FEP_ASSERT_NOW(a_stall_cause, !in_ready_o, out_valid_o,
                  "input blocked without a waiting result")

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import fep_pkg::*;

  typedef struct packed {
    logic [31:0] y_bits;
    logic        last_res;
    logic        domain_error;
  } exp_result_t;

  localparam int CycleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] x_bits_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] y_bits_o;
  logic        last_res_o;
  logic        domain_error_o;

  exp_result_t pending_results[$];
  int          mismatch_cnt = 0;
  int          cycle_cnt = 0;
  bit          no_idle = 1'b0;
  int          hold_req = 0;
  bit          beat_taken = 1'b0;
  int          rx_stall = 0;
  int          rx_hold = 0;

  float_exp_poly_unit_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .x_bits_i      (x_bits_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .y_bits_o      (y_bits_o),
    .last_res_o    (last_res_o),
    .domain_error_o(domain_error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL float_exp_poly_unit_top");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Bit-exact binary32 arithmetic
  // ---------------------------------------------------------------------------
  function automatic bit fp_is_nan(logic [31:0] v);
    return v[30:0] > 31'h7F80_0000;
  endfunction

  function automatic bit fp_is_inf(logic [31:0] v);
    return v[30:0] == 31'h7F80_0000;
  endfunction

  function automatic bit fp_is_zero(logic [31:0] v);
    return v[30:0] == 31'd0;
  endfunction

  // Significand and biased exponent such that value = m * 2^(e-150).
  function automatic void fp_unpack(input logic [31:0] v, output logic [63:0] m,
                                    output int e);
    if (v[30:23] == 8'd0) begin
      m = {41'd0, v[22:0]};
      e = 1;
    end else begin
      m = {40'd0, 1'b1, v[22:0]};
      e = int'(v[30:23]);
    end
  endfunction

  function automatic logic [63:0] shr_sticky(logic [63:0] x, int d);
    logic [63:0] lost;
    if (d <= 0) return x;
    if (d >= 63) return (x != 0) ? 64'd1 : 64'd0;
    lost = x & ((64'd1 << d) - 64'd1);
    x = x >> d;
    return (lost != 0) ? (x | 64'd1) : x;
  endfunction

  function automatic logic [31:0] fp_round(logic [31:0] sgn, logic [63:0] r_in, int e_in);
    logic [63:0] r, mant, rem, half;
    int e, be, sh;
    r = r_in;
    e = e_in;
    while (r[63:62] == 2'b00) begin
      r = r << 1;
      e--;
    end
    be = 62 + e + 127;
    if (be > 254) return sgn | 32'h7F80_0000;
    sh = 39;
    if (be < 1) begin
      sh += 1 - be;
      be = 1;
    end
    if (sh >= 64) return sgn;
    mant = r >> sh;
    rem  = r & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && mant[0])) mant++;
    return sgn | 32'(((64'(be - 1)) << 23) + mant);
  endfunction

  function automatic logic [31:0] fused_mac(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic [31:0] sp, sc, sr;
    logic [63:0] ma, mb, mc, mp, r;
    int ea, eb, ec, ep, e;
    sp = (a ^ b) & SignBit;
    sc = c & SignBit;
    if (fp_is_nan(a) || fp_is_nan(b) || fp_is_nan(c)) return QnanBits;
    if (fp_is_inf(a) || fp_is_inf(b)) begin
      if (fp_is_zero(a) || fp_is_zero(b)) return QnanBits;
      if (fp_is_inf(c) && sc != sp) return QnanBits;
      return sp | 32'h7F80_0000;
    end
    if (fp_is_inf(c)) return c;
    if (fp_is_zero(a) || fp_is_zero(b)) begin
      if (fp_is_zero(c)) return (sp != 0 && sc != 0) ? SignBit : 32'd0;
      return c;
    end
    fp_unpack(a, ma, ea);
    fp_unpack(b, mb, eb);
    mp = ma * mb;
    ep = ea + eb - 300;
    while (mp[63:61] == 3'b000) begin
      mp = mp << 1;
      ep--;
    end
    if (fp_is_zero(c)) return fp_round(sp, mp, ep);
    fp_unpack(c, mc, ec);
    ec -= 150;
    while (mc[63:61] == 3'b000) begin
      mc = mc << 1;
      ec--;
    end
    if (ep >= ec) begin
      mc = shr_sticky(mc, ep - ec);
      e = ep;
    end else begin
      mp = shr_sticky(mp, ec - ep);
      e = ec;
    end
    if (sp == sc) begin
      r = mp + mc;
      sr = sp;
    end else if (mp >= mc) begin
      r = mp - mc;
      sr = sp;
    end else begin
      r = mc - mp;
      sr = sc;
    end
    if (r == 0) return 32'd0;
    return fp_round(sr, r, e);
  endfunction

  function automatic logic [31:0] predict_exp(logic [31:0] x);
    logic [31:0] z, n, b, k, u, p, q, j;
    z = fused_mac(x, Log2e, Shifter);
    n = fused_mac(z, OneBits, Shifter ^ SignBit);
    b = fused_mac(n, Ln2Hi ^ SignBit, x);
    b = fused_mac(n, Ln2Lo ^ SignBit, b);
    k = (z << ExpShift) + OneBits;
    u = fused_mac(b, b, SignBit);
    p = fused_mac(Pc2, b, Pc1);
    q = fused_mac(Pc4, b, Pc3);
    p = fused_mac(q, u, p);
    j = fused_mac(p, u, fused_mac(Pc0, b, SignBit));
    return fused_mac(j, k, k);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender, receiver and result checker
  // ---------------------------------------------------------------------------
  task automatic send_arg(logic [31:0] x, logic lst);
    int gap;
    bit ok;
    exp_result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_bits_i   <= x;
    last_i     <= lst;
    do begin
      @(negedge clk_i);
      ok = in_ready_o;
      @(posedge clk_i);
    end while (!ok);
    res.y_bits       = predict_exp(x);
    res.last_res     = lst;
    res.domain_error = x[30:0] > Limit80[30:0];
    pending_results.push_back(res);
  endtask

  // The ready line only changes at the rising edge, so it is stable at the falling one.
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      rx_hold  = hold_req;
      hold_req = 0;
    end
    if (beat_taken) begin
      beat_taken = 1'b0;
      rx_stall = no_idle ? 0 : $urandom_range(0, 3);
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(negedge clk_i) begin
    exp_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beat_taken = 1'b1;
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result beat: y=%h last=%b derr=%b",
                   y_bits_o, last_res_o, domain_error_o);
      end else begin
        want = pending_results.pop_front();
        if (y_bits_o !== want.y_bits || last_res_o !== want.last_res ||
            domain_error_o !== want.domain_error) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp y=%h last=%b derr=%b, got y=%h last=%b derr=%b",
                     want.y_bits, want.last_res, want.domain_error,
                     y_bits_o, last_res_o, domain_error_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rand_arg();
    logic [31:0] v;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      // Finite argument inside the supported range.
      do begin
        v = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'($urandom_range(90, 133)),
             23'($urandom)};
      end while (v[30:0] > Limit80[30:0]);
    end else if (sel < 85) begin
      v = $urandom;
    end else begin
      // Near the range edge and the overflow and underflow points.
      v = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'($urandom_range(132, 134)),
           23'($urandom)};
    end
    return v;
  endfunction

  task automatic test_directed();
    logic [31:0] args[] = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                            32'h42A0_0000, 32'hC2A0_0000, 32'h42A0_0001, 32'hC2A0_0001,
                            32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
                            32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF,
                            32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h42B1_7218, 32'hC2AE_8000,
                            32'hC2CE_0000, 32'h3F00_0000, 32'h3F31_7218, 32'h322B_CC77};
    foreach (args[i]) send_arg(args[i], i[0]);
  endtask

  task automatic test_random(int count);
    repeat (count) send_arg(rand_arg(), ($urandom_range(0, 7) == 0));
  endtask

  task automatic test_back_to_back(int count);
    no_idle = 1'b1;
    repeat (count) send_arg(rand_arg(), $urandom_range(0, 1));
    no_idle = 1'b0;
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall the input.
  task automatic test_backpressure(int count);
    hold_req = 120;
    no_idle = 1'b1;
    repeat (count) send_arg(rand_arg(), $urandom_range(0, 1));
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(500);
    test_back_to_back(200);
    test_backpressure(100);
    test_random(300);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PipeLat + 20) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("PASS float_exp_poly_unit_top");
    end else begin
      $display("FAIL float_exp_poly_unit_top");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/fep_pkg.sv
hdl/fep_fma.sv
hdl/float_exp_poly_unit_top.sv
dv/tb_top.sv
